// File: rtl/core/rmll_pkg.sv
// ----------------------------------------------------------------------------
// Quadrilateral centerline package
// Shared widths for the coordinate words and the internal arithmetic.
// ----------------------------------------------------------------------------
package rmll_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int SUM_WIDTH   = COORD_WIDTH + 2;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 3;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int EDGE_WIDTH  = COORD_WIDTH + 1;
  localparam int SQ_WIDTH    = 2 * EDGE_WIDTH;
  localparam int LEN_WIDTH   = SQ_WIDTH + 1;

endpackage

// File: rtl/core/rmll_if.sv
// ----------------------------------------------------------------------------
// Quadrilateral centerline channels
// Valid/ready channels for the vertex word and the centerline word.
// ----------------------------------------------------------------------------
interface rmll_quad_if import rmll_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex0_x;
  logic signed [COORD_WIDTH-1:0] vertex0_y;
  logic signed [COORD_WIDTH-1:0] vertex1_x;
  logic signed [COORD_WIDTH-1:0] vertex1_y;
  logic signed [COORD_WIDTH-1:0] vertex2_x;
  logic signed [COORD_WIDTH-1:0] vertex2_y;
  logic signed [COORD_WIDTH-1:0] vertex3_x;
  logic signed [COORD_WIDTH-1:0] vertex3_y;

  modport source (
    output valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
           vertex2_x, vertex2_y, vertex3_x, vertex3_y,
    input  ready
  );
  modport sink (
    input  valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
           vertex2_x, vertex2_y, vertex3_x, vertex3_y,
    output ready
  );
endinterface

interface rmll_line_if import rmll_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] line_start_x;
  logic signed [COORD_WIDTH-1:0] line_start_y;
  logic signed [COORD_WIDTH-1:0] line_end_x;
  logic signed [COORD_WIDTH-1:0] line_end_y;
  logic [1:0]                    longest_edge_start;
  logic                          duplicate_vertex;

  modport source (
    output valid, line_start_x, line_start_y, line_end_x, line_end_y,
           longest_edge_start, duplicate_vertex,
    input  ready
  );
  modport sink (
    input  valid, line_start_x, line_start_y, line_end_x, line_end_y,
           longest_edge_start, duplicate_vertex,
    output ready
  );
endinterface

// File: rtl/core/rect_middle_long_line_core.sv
// ----------------------------------------------------------------------------
// Quadrilateral centerline core
// Sorts four vertices by angle about their centroid, finds the first longest
// edge and returns the line joining the midpoints of the edges flanking it.
// ----------------------------------------------------------------------------
// The quad channel takes one word of four vertices, the cline channel returns
// one centerline word for each of them, in order.
// Throughput is one word per cycle while cline does not stall; the seven stages
// are centroid offsets, cross products, ranking and reorder, edge squares,
// edge lengths, longest edge selection and midpoints. Each multiplier stage
// holds one product per register, which sets the stage depth.
// Each stage holds its word until the next stage has room, so a stall on
// cline fills the empty stages first and only then drops quad.ready.
// No word is lost or repeated during a stall.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module rect_middle_long_line_core import rmll_pkg::*; (
  input logic        clk,
  input logic        rst,
  rmll_quad_if.sink  quad,
  rmll_line_if.source cline
);

  localparam int STAGES    = 7;
  localparam int NUM_PAIRS = 6;
  localparam logic [1:0] PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  always_comb begin
    for (int i = 0; i < STAGES - 1; i++) begin
      en[i] = !vld[i] || en[i+1];
    end
    en[STAGES-1] = !vld[STAGES-1] || cline.ready;
  end

  assign quad.ready  = en[0];
  assign cline.valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= quad.valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: offsets from the centroid, scaled by four.
  logic signed [COORD_WIDTH-1:0] in_x [4];
  logic signed [COORD_WIDTH-1:0] in_y [4];
  logic signed [SUM_WIDTH-1:0]   sum_x, sum_y;
  logic signed [DIFF_WIDTH-1:0]  ofs_x [4];
  logic signed [DIFF_WIDTH-1:0]  ofs_y [4];
  logic                          dup;

  assign in_x[0] = quad.vertex0_x;
  assign in_y[0] = quad.vertex0_y;
  assign in_x[1] = quad.vertex1_x;
  assign in_y[1] = quad.vertex1_y;
  assign in_x[2] = quad.vertex2_x;
  assign in_y[2] = quad.vertex2_y;
  assign in_x[3] = quad.vertex3_x;
  assign in_y[3] = quad.vertex3_y;

  always_comb begin
    sum_x = SUM_WIDTH'(in_x[0]) + SUM_WIDTH'(in_x[1]) + SUM_WIDTH'(in_x[2])
          + SUM_WIDTH'(in_x[3]);
    sum_y = SUM_WIDTH'(in_y[0]) + SUM_WIDTH'(in_y[1]) + SUM_WIDTH'(in_y[2])
          + SUM_WIDTH'(in_y[3]);
    for (int i = 0; i < 4; i++) begin
      ofs_x[i] = $signed({in_x[i][COORD_WIDTH-1], in_x[i], 2'b00}) - DIFF_WIDTH'(sum_x);
      ofs_y[i] = $signed({in_y[i][COORD_WIDTH-1], in_y[i], 2'b00}) - DIFF_WIDTH'(sum_y);
      // A vertex at the centroid is treated as lying along the positive x axis.
      if (ofs_x[i] == '0 && ofs_y[i] == '0) begin
        ofs_x[i] = DIFF_WIDTH'(1);
      end
    end
    dup = 1'b0;
    for (int pr = 0; pr < NUM_PAIRS; pr++) begin
      if (in_x[PAIR_A[pr]] == in_x[PAIR_B[pr]] && in_y[PAIR_A[pr]] == in_y[PAIR_B[pr]]) begin
        dup = 1'b1;
      end
    end
  end

  logic signed [COORD_WIDTH-1:0] s1_vx [4];
  logic signed [COORD_WIDTH-1:0] s1_vy [4];
  logic signed [DIFF_WIDTH-1:0]  s1_dx [4];
  logic signed [DIFF_WIDTH-1:0]  s1_dy [4];
  logic                          s1_dup;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_vx  <= in_x;
      s1_vy  <= in_y;
      s1_dx  <= ofs_x;
      s1_dy  <= ofs_y;
      s1_dup <= dup;
    end
  end

  // Stage 2: cross products of every pair and the half-plane of each offset.
  logic signed [PROD_WIDTH-1:0]  s2_p [NUM_PAIRS];
  logic signed [PROD_WIDTH-1:0]  s2_q [NUM_PAIRS];
  logic [3:0]                    s2_up;
  logic signed [COORD_WIDTH-1:0] s2_vx [4];
  logic signed [COORD_WIDTH-1:0] s2_vy [4];
  logic                          s2_dup;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int pr = 0; pr < NUM_PAIRS; pr++) begin
        s2_p[pr] <= PROD_WIDTH'(s1_dx[PAIR_A[pr]]) * PROD_WIDTH'(s1_dy[PAIR_B[pr]]);
        s2_q[pr] <= PROD_WIDTH'(s1_dy[PAIR_A[pr]]) * PROD_WIDTH'(s1_dx[PAIR_B[pr]]);
      end
      for (int i = 0; i < 4; i++) begin
        s2_up[i] <= (!s1_dy[i][DIFF_WIDTH-1] && s1_dy[i] != '0)
                 || (s1_dy[i] == '0 && s1_dx[i][DIFF_WIDTH-1]);
      end
      s2_vx  <= s1_vx;
      s2_vy  <= s1_vy;
      s2_dup <= s1_dup;
    end
  end

  // Stage 3: stable ranking by angle and reorder of the vertices.
  logic [3:0]                    bef [4];
  logic [1:0]                    rank [4];
  logic signed [COORD_WIDTH-1:0] srt_x [4];
  logic signed [COORD_WIDTH-1:0] srt_y [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bef[i] = '0;
    end
    for (int pr = 0; pr < NUM_PAIRS; pr++) begin
      if (s2_up[PAIR_A[pr]] == s2_up[PAIR_B[pr]]) begin
        bef[PAIR_A[pr]][PAIR_B[pr]] = s2_p[pr] > s2_q[pr];
        bef[PAIR_B[pr]][PAIR_A[pr]] = s2_q[pr] > s2_p[pr];
      end else begin
        bef[PAIR_A[pr]][PAIR_B[pr]] = !s2_up[PAIR_A[pr]];
        bef[PAIR_B[pr]][PAIR_A[pr]] = !s2_up[PAIR_B[pr]];
      end
    end
    for (int i = 0; i < 4; i++) begin
      rank[i] = 2'd0;
      for (int j = 0; j < 4; j++) begin
        if (j < i && !bef[i][j]) begin
          rank[i] = rank[i] + 2'd1;
        end
        if (j > i && bef[j][i]) begin
          rank[i] = rank[i] + 2'd1;
        end
      end
    end
    for (int r = 0; r < 4; r++) begin
      srt_x[r] = '0;
      srt_y[r] = '0;
      for (int i = 0; i < 4; i++) begin
        if (rank[i] == 2'(r)) begin
          srt_x[r] = s2_vx[i];
          srt_y[r] = s2_vy[i];
        end
      end
    end
  end

  logic signed [COORD_WIDTH-1:0] s3_px [4];
  logic signed [COORD_WIDTH-1:0] s3_py [4];
  logic                          s3_dup;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_px  <= srt_x;
      s3_py  <= srt_y;
      s3_dup <= s2_dup;
    end
  end

  // Stage 4: squared edge components.
  logic signed [EDGE_WIDTH-1:0] ex [4];
  logic signed [EDGE_WIDTH-1:0] ey [4];
  logic [EDGE_WIDTH-1:0]        mx [4];
  logic [EDGE_WIDTH-1:0]        my [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ex[i] = $signed({s3_px[i][COORD_WIDTH-1], s3_px[i]})
            - $signed({s3_px[2'(i+1)][COORD_WIDTH-1], s3_px[2'(i+1)]});
      ey[i] = $signed({s3_py[i][COORD_WIDTH-1], s3_py[i]})
            - $signed({s3_py[2'(i+1)][COORD_WIDTH-1], s3_py[2'(i+1)]});
      mx[i] = ex[i][EDGE_WIDTH-1] ? EDGE_WIDTH'(-ex[i]) : EDGE_WIDTH'(ex[i]);
      my[i] = ey[i][EDGE_WIDTH-1] ? EDGE_WIDTH'(-ey[i]) : EDGE_WIDTH'(ey[i]);
    end
  end

  logic [SQ_WIDTH-1:0]           s4_sqx [4];
  logic [SQ_WIDTH-1:0]           s4_sqy [4];
  logic signed [COORD_WIDTH-1:0] s4_px [4];
  logic signed [COORD_WIDTH-1:0] s4_py [4];
  logic                          s4_dup;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        s4_sqx[i] <= SQ_WIDTH'(mx[i]) * SQ_WIDTH'(mx[i]);
        s4_sqy[i] <= SQ_WIDTH'(my[i]) * SQ_WIDTH'(my[i]);
      end
      s4_px  <= s3_px;
      s4_py  <= s3_py;
      s4_dup <= s3_dup;
    end
  end

  // Stage 5: squared edge lengths.
  logic [LEN_WIDTH-1:0]          s5_len [4];
  logic signed [COORD_WIDTH-1:0] s5_px [4];
  logic signed [COORD_WIDTH-1:0] s5_py [4];
  logic                          s5_dup;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 4; i++) begin
        s5_len[i] <= LEN_WIDTH'(s4_sqx[i]) + LEN_WIDTH'(s4_sqy[i]);
      end
      s5_px  <= s4_px;
      s5_py  <= s4_py;
      s5_dup <= s4_dup;
    end
  end

  // Stage 6: the first longest edge wins ties.
  logic [3:0] chosen;
  logic [1:0] k_sel;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      chosen[i] = 1'b1;
      for (int j = 0; j < 4; j++) begin
        if (j < i && !(s5_len[i] > s5_len[j])) begin
          chosen[i] = 1'b0;
        end
        if (j > i && s5_len[i] < s5_len[j]) begin
          chosen[i] = 1'b0;
        end
      end
    end
    k_sel = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (chosen[i]) begin
        k_sel = 2'(i);
      end
    end
  end

  logic [1:0]                    s6_k;
  logic signed [COORD_WIDTH-1:0] s6_px [4];
  logic signed [COORD_WIDTH-1:0] s6_py [4];
  logic                          s6_dup;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_k   <= k_sel;
      s6_px  <= s5_px;
      s6_py  <= s5_py;
      s6_dup <= s5_dup;
    end
  end

  // Stage 7: midpoints of the edges flanking the longest edge, rounded toward minus infinity.
  logic [1:0]                  k1, k2, k3;
  logic signed [COORD_WIDTH:0] msx, msy, mex, mey;

  always_comb begin
    k1  = s6_k + 2'd1;
    k2  = s6_k + 2'd2;
    k3  = s6_k + 2'd3;
    msx = $signed({s6_px[s6_k][COORD_WIDTH-1], s6_px[s6_k]})
        + $signed({s6_px[k3][COORD_WIDTH-1], s6_px[k3]});
    msy = $signed({s6_py[s6_k][COORD_WIDTH-1], s6_py[s6_k]})
        + $signed({s6_py[k3][COORD_WIDTH-1], s6_py[k3]});
    mex = $signed({s6_px[k1][COORD_WIDTH-1], s6_px[k1]})
        + $signed({s6_px[k2][COORD_WIDTH-1], s6_px[k2]});
    mey = $signed({s6_py[k1][COORD_WIDTH-1], s6_py[k1]})
        + $signed({s6_py[k2][COORD_WIDTH-1], s6_py[k2]});
  end

  logic signed [COORD_WIDTH-1:0] s7_sx, s7_sy, s7_ex, s7_ey;
  logic [1:0]                    s7_k;
  logic                          s7_dup;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_sx  <= $signed(msx[COORD_WIDTH:1]);
      s7_sy  <= $signed(msy[COORD_WIDTH:1]);
      s7_ex  <= $signed(mex[COORD_WIDTH:1]);
      s7_ey  <= $signed(mey[COORD_WIDTH:1]);
      s7_k   <= s6_k;
      s7_dup <= s6_dup;
    end
  end

  assign cline.line_start_x       = s7_sx;
  assign cline.line_start_y       = s7_sy;
  assign cline.line_end_x         = s7_ex;
  assign cline.line_end_y         = s7_ey;
  assign cline.longest_edge_start = s7_k;
  assign cline.duplicate_vertex   = s7_dup;

`ifndef ASSERT_OFF
  a_ranks_distinct: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (rank[0] != rank[1] && rank[0] != rank[2] && rank[0] != rank[3]
             && rank[1] != rank[2] && rank[1] != rank[3] && rank[2] != rank[3]))
    else $error("vertex ranks are not a permutation");

  a_one_longest: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> $onehot(chosen))
    else $error("longest edge selection is not unique");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !quad.ready |-> &vld)
    else $error("input blocked while a stage is empty");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    vld[2] && !en[3] |=> vld[2] && $stable(s3_dup))
    else $error("stalled stage lost its word");
`endif

endmodule

// File: bench/rect_middle_long_line_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrilateral centerline core testbench
// Drives vertex words through the quad channel under random idling, predicts
// each centerline word from an exact angle sort and edge compare, and checks
// every word that leaves the cline channel in order.
// ----------------------------------------------------------------------------
module rect_middle_long_line_core_tb;
  import rmll_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 317;
  localparam int PRINT_LIMIT = 100;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } point_t;

  typedef struct {
    point_t v [4];
  } quad_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic [1:0]                    edge_start;
    logic                          dup;
  } line_t;

  class centerline_book;
    line_t pending_lines [$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    task report_mismatch(string what);
      if (errors < PRINT_LIMIT) begin
        $display("[%0t] mismatch: %s", $time, what);
      end
      errors++;
    endtask

    function bit angle_before(logic signed [DIFF_WIDTH-1:0] ax,
                              logic signed [DIFF_WIDTH-1:0] ay,
                              logic signed [DIFF_WIDTH-1:0] bx,
                              logic signed [DIFF_WIDTH-1:0] by);
      bit ha;
      bit hb;
      logic signed [PROD_WIDTH-1:0] lhs;
      logic signed [PROD_WIDTH-1:0] rhs;
      ha = (ay > 0) || (ay == 0 && ax < 0);
      hb = (by > 0) || (by == 0 && bx < 0);
      if (ha != hb) begin
        return !ha && hb;
      end
      lhs = PROD_WIDTH'(ax) * PROD_WIDTH'(by);
      rhs = PROD_WIDTH'(ay) * PROD_WIDTH'(bx);
      return lhs > rhs;
    endfunction

    function logic signed [LEN_WIDTH-1:0] edge_square(point_t a, point_t b);
      logic signed [EDGE_WIDTH-1:0] ex;
      logic signed [EDGE_WIDTH-1:0] ey;
      ex = EDGE_WIDTH'(a.x) - EDGE_WIDTH'(b.x);
      ey = EDGE_WIDTH'(a.y) - EDGE_WIDTH'(b.y);
      return LEN_WIDTH'(ex) * LEN_WIDTH'(ex) + LEN_WIDTH'(ey) * LEN_WIDTH'(ey);
    endfunction

    function logic signed [COORD_WIDTH-1:0] half_floor(logic signed [COORD_WIDTH-1:0] a,
                                                        logic signed [COORD_WIDTH-1:0] b);
      logic signed [EDGE_WIDTH-1:0] s;
      s = EDGE_WIDTH'(a) + EDGE_WIDTH'(b);
      s = s >>> 1;
      return s[COORD_WIDTH-1:0];
    endfunction

    function line_t predict_centerline(quad_t q);
      logic signed [SUM_WIDTH-1:0]  sum_x;
      logic signed [SUM_WIDTH-1:0]  sum_y;
      logic signed [DIFF_WIDTH-1:0] dx [4];
      logic signed [DIFF_WIDTH-1:0] dy [4];
      logic signed [LEN_WIDTH-1:0]  best;
      logic signed [LEN_WIDTH-1:0]  len;
      int     order [4];
      int     cur;
      int     j;
      int     k;
      point_t p [4];
      line_t  r;
      sum_x = SUM_WIDTH'(q.v[0].x) + SUM_WIDTH'(q.v[1].x) + SUM_WIDTH'(q.v[2].x)
            + SUM_WIDTH'(q.v[3].x);
      sum_y = SUM_WIDTH'(q.v[0].y) + SUM_WIDTH'(q.v[1].y) + SUM_WIDTH'(q.v[2].y)
            + SUM_WIDTH'(q.v[3].y);
      r.dup = 1'b0;
      for (int i = 0; i < 4; i++) begin
        dx[i] = (DIFF_WIDTH'(q.v[i].x) <<< 2) - DIFF_WIDTH'(sum_x);
        dy[i] = (DIFF_WIDTH'(q.v[i].y) <<< 2) - DIFF_WIDTH'(sum_y);
        if (dx[i] == 0 && dy[i] == 0) begin
          dx[i] = DIFF_WIDTH'(1);
        end
        order[i] = i;
        for (int m = i + 1; m < 4; m++) begin
          if (q.v[i].x == q.v[m].x && q.v[i].y == q.v[m].y) begin
            r.dup = 1'b1;
          end
        end
      end
      for (int i = 1; i < 4; i++) begin
        cur = order[i];
        j = i;
        while (j > 0 && angle_before(dx[cur], dy[cur], dx[order[j-1]], dy[order[j-1]])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = cur;
      end
      for (int i = 0; i < 4; i++) begin
        p[i] = q.v[order[i]];
      end
      k = 0;
      best = edge_square(p[0], p[1]);
      for (int i = 1; i < 4; i++) begin
        len = edge_square(p[i], p[(i + 1) % 4]);
        if (len > best) begin
          best = len;
          k = i;
        end
      end
      r.start_x    = half_floor(p[k].x, p[(k + 3) % 4].x);
      r.start_y    = half_floor(p[k].y, p[(k + 3) % 4].y);
      r.end_x      = half_floor(p[(k + 1) % 4].x, p[(k + 2) % 4].x);
      r.end_y      = half_floor(p[(k + 1) % 4].y, p[(k + 2) % 4].y);
      r.edge_start = k[1:0];
      return r;
    endfunction

    function void note_quad(quad_t q);
      pending_lines = {pending_lines, predict_centerline(q)};
    endfunction

    function int pending();
      return pending_lines.size();
    endfunction

    task check_line(line_t got);
      line_t want;
      if (pending_lines.size() == 0) begin
        report_mismatch("centerline word with no vertex word outstanding");
      end else begin
        want = pending_lines.pop_front();
        if (got.start_x !== want.start_x)
          report_mismatch($sformatf("line_start_x got %0d expected %0d",
                                    got.start_x, want.start_x));
        if (got.start_y !== want.start_y)
          report_mismatch($sformatf("line_start_y got %0d expected %0d",
                                    got.start_y, want.start_y));
        if (got.end_x !== want.end_x)
          report_mismatch($sformatf("line_end_x got %0d expected %0d",
                                    got.end_x, want.end_x));
        if (got.end_y !== want.end_y)
          report_mismatch($sformatf("line_end_y got %0d expected %0d",
                                    got.end_y, want.end_y));
        if (got.edge_start !== want.edge_start)
          report_mismatch($sformatf("longest_edge_start got %0d expected %0d",
                                    got.edge_start, want.edge_start));
        if (got.dup !== want.dup)
          report_mismatch($sformatf("duplicate_vertex got %0b expected %0b",
                                    got.dup, want.dup));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   send_idle_pct;
  int   recv_idle_pct;

  centerline_book book = new();

  rmll_quad_if quad_ch ();
  rmll_line_if line_ch ();

  rect_middle_long_line_core dut (
    .clk   (clk),
    .rst   (rst),
    .quad  (quad_ch),
    .cline (line_ch)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rect_middle_long_line_core regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    line_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    line_t got;
    if (!rst && line_ch.valid && line_ch.ready) begin
      got.start_x    = line_ch.line_start_x;
      got.start_y    = line_ch.line_start_y;
      got.end_x      = line_ch.line_end_x;
      got.end_y      = line_ch.line_end_y;
      got.edge_start = line_ch.longest_edge_start;
      got.dup        = line_ch.duplicate_vertex;
      book.check_line(got);
    end
  end

  function automatic quad_t make_quad(int x0, int y0, int x1, int y1,
                                      int x2, int y2, int x3, int y3);
    quad_t q;
    q.v[0].x = COORD_WIDTH'(x0); q.v[0].y = COORD_WIDTH'(y0);
    q.v[1].x = COORD_WIDTH'(x1); q.v[1].y = COORD_WIDTH'(y1);
    q.v[2].x = COORD_WIDTH'(x2); q.v[2].y = COORD_WIDTH'(y2);
    q.v[3].x = COORD_WIDTH'(x3); q.v[3].y = COORD_WIDTH'(y3);
    return q;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return COORD_WIDTH'(-1);
      default: return COORD_WIDTH'(1);
    endcase
  endfunction

  function automatic quad_t make_random_quad();
    quad_t  q;
    point_t t;
    int     kind;
    int     cx;
    int     cy;
    int     ux;
    int     uy;
    int     wx;
    int     wy;
    int     s;
    int     j;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      for (int i = 0; i < 4; i++) begin
        q.v[i].x = COORD_WIDTH'($urandom());
        q.v[i].y = COORD_WIDTH'($urandom());
      end
    end else if (kind <= 4) begin
      for (int i = 0; i < 4; i++) begin
        q.v[i].x = COORD_WIDTH'(int'($urandom_range(0, 16)) - 8);
        q.v[i].y = COORD_WIDTH'(int'($urandom_range(0, 16)) - 8);
      end
    end else if (kind <= 8) begin
      // Rotated rectangle or parallelogram, random center, shuffled corners.
      cx = $urandom_range(0, 2 ** 21) - 2 ** 20;
      cy = $urandom_range(0, 2 ** 21) - 2 ** 20;
      ux = $urandom_range(0, 2048) - 1024;
      uy = $urandom_range(0, 2048) - 1024;
      s  = $urandom_range(1, 512);
      wx = -uy * s;
      wy = ux * s;
      if ($urandom_range(0, 1)) begin
        ux = ux * $urandom_range(1, 512);
        uy = uy * $urandom_range(1, 512);
        wx = wx / 512;
        wy = wy / 512;
      end
      q = make_quad(cx + ux + wx, cy + uy + wy, cx + ux - wx, cy + uy - wy,
                    cx - ux - wx, cy - uy - wy, cx - ux + wx, cy - uy + wy);
      for (int i = 3; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = q.v[i];
        q.v[i] = q.v[j];
        q.v[j] = t;
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        q.v[i].x = pick_extreme();
        q.v[i].y = pick_extreme();
      end
    end
    return q;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_quad(quad_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      quad_ch.valid <= 1'b0;
      @(negedge clk);
    end
    quad_ch.valid     <= 1'b1;
    quad_ch.vertex0_x <= q.v[0].x;
    quad_ch.vertex0_y <= q.v[0].y;
    quad_ch.vertex1_x <= q.v[1].x;
    quad_ch.vertex1_y <= q.v[1].y;
    quad_ch.vertex2_x <= q.v[2].x;
    quad_ch.vertex2_y <= q.v[2].y;
    quad_ch.vertex3_x <= q.v[3].x;
    quad_ch.vertex3_y <= q.v[3].y;
    do @(posedge clk); while (!quad_ch.ready);
    book.note_quad(q);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    quad_ch.valid <= 1'b0;
    @(negedge clk);
    while (book.pending() != 0) @(negedge clk);
  endtask

  initial begin
    quad_t directed [$];
    clk               = 1'b0;
    rst               = 1'b1;
    cycles            = 0;
    send_idle_pct     = 28;
    recv_idle_pct     = 46;
    quad_ch.valid     = 1'b0;
    quad_ch.vertex0_x = '0;
    quad_ch.vertex0_y = '0;
    quad_ch.vertex1_x = '0;
    quad_ch.vertex1_y = '0;
    quad_ch.vertex2_x = '0;
    quad_ch.vertex2_y = '0;
    quad_ch.vertex3_x = '0;
    quad_ch.vertex3_y = '0;
    line_ch.ready     = 1'b0;

    directed = {directed, make_quad(0, 0, 0, 0, 0, 0, 0, 0)};
    directed = {directed, make_quad(0, 0, 1024, 0, 1024, 256, 0, 256)};
    directed = {directed, make_quad(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                                    COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX)};
    directed = {directed, make_quad(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                                    COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN)};
    directed = {directed, make_quad(-256, -256, 256, -256, 256, 256, -256, 256)};
    directed = {directed, make_quad(0, 0, 1, 0, 2, 0, 3, 0)};
    directed = {directed, make_quad(3, 0, 2, 0, 1, 0, 0, 0)};
    directed = {directed, make_quad(0, 0, 4, 0, -4, 4, 0, -4)};
    directed = {directed, make_quad(10, 10, 10, 10, -20, 5, 7, -30)};
    directed = {directed, make_quad(-1, -3, 2, -1, 3, 4, -5, 2)};
    directed = {directed, make_quad(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                    COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN)};
    directed = {directed, make_quad(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                    COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX)};
    directed = {directed, make_quad(0, COORD_MIN, 1, COORD_MIN, 1, COORD_MAX,
                                    0, COORD_MAX)};
    directed = {directed, make_quad(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                    COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN)};
    directed = {directed, make_quad(0, 0, 2, 2, 4, 4, -6, -6)};
    directed = {directed, make_quad(-8, 0, 8, 0, 0, 3, 0, -3)};
    directed = {directed, make_quad(-1, -1, 1, -1, 1, 1, -1, 1)};
    for (int i = 0; i < 6; i++) begin
      directed = {directed, make_quad(pick_extreme(), pick_extreme(), pick_extreme(),
                                      pick_extreme(), pick_extreme(), pick_extreme(),
                                      pick_extreme(), pick_extreme())};
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_quad(directed[i]);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_for_drain();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_quad(make_random_quad());
      end
    end

    quad_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (book.errors == 0) begin
      $display("rect_middle_long_line_core regression: pass");
    end else begin
      $display("rect_middle_long_line_core regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/rmll_pkg.sv
rtl/core/rmll_if.sv
rtl/core/rect_middle_long_line_core.sv
bench/rect_middle_long_line_core_tb.sv
